[rtl/cnrf_pkg.sv]
// Shared types, constants and saturating arithmetic for the complex Newton root finder.
// No dependencies; every other file of the block imports this package.
package cnrf_pkg;

    localparam int FRAC_BITS  = 40;
    localparam int MAX_DEGREE = 5;
    localparam int COEFS      = MAX_DEGREE + 1;
    localparam int ROOT_SLOTS = 16;
    localparam int SLOT_W     = 4;
    localparam int CNT_W      = 5;
    localparam int DEG_W      = 3;
    localparam int LIMIT_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 136;
    localparam int DIV_STEPS  = 128 + FRAC_BITS;
    localparam int DIV_CW     = $clog2(DIV_STEPS);

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_5 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd7;

    localparam logic [DEG_W-1:0]   DEGREE_RESET = 3'd1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 10'd85;

    // Residual tolerance about 1e-7 and match radius about 1e-3, squared
    localparam logic [63:0]  TOL_RAW   = (64'd1 << FRAC_BITS) / 64'd10000000;
    localparam logic [63:0]  MATCH_RAW = (64'd1 << FRAC_BITS) / 64'd1000;
    localparam logic [127:0] TOL2      = 128'(TOL_RAW) * 128'(TOL_RAW);
    localparam logic [127:0] MATCH2    = 128'(MATCH_RAW) * 128'(MATCH_RAW);

    localparam logic signed [63:0] WORD_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] WORD_MIN = 64'sh8000_0000_0000_0000;

    typedef logic signed [63:0] word_t;

    typedef enum logic [4:0] {
        S_IDLE, S_SLOPE, S_HSTEP, S_HMUL, S_HADD, S_FDONE, S_M2, S_FRDONE,
        S_CHECK, S_GDONE, S_DENDONE, S_NUM, S_DIV, S_XUPD, S_TSTART, S_TSCAN,
        S_TRD, S_DDONE, S_RDONE, S_RRDONE, S_APPEND, S_OUT
    } state_t;

    function automatic word_t sadd64(input word_t a, input word_t b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? WORD_MIN : WORD_MAX;
        return s[63:0];
    endfunction

    function automatic word_t ssub64(input word_t a, input word_t b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? WORD_MIN : WORD_MAX;
        return s[63:0];
    endfunction

    // Apply a sign to a magnitude and clamp to the signed word range
    function automatic word_t sat_mag(input logic [63:0] m, input logic neg, input logic over);
        if (neg) begin
            if (over || m[63]) return WORD_MIN;
            return -$signed(m);
        end
        if (over || m[63]) return WORD_MAX;
        return $signed(m);
    endfunction

    // Truncate a full magnitude product to the fixed-point format and saturate
    function automatic word_t fmul_post(input logic [127:0] p, input logic neg);
        return sat_mag(p[FRAC_BITS+63:FRAC_BITS], neg, |p[127:FRAC_BITS+64]);
    endfunction

endpackage

[rtl/complex_newton_root_finder_unit.sv]
// Complex Newton root finder: top level with sequencer, root table and configuration.
// Depends on cnrf_pkg, cnrf_mul and cnrf_div.
//
// Each start point transfer runs Newton steps x <- x - p(x)/p'(x) on the configured
// real polynomial in saturating Q23.40, then matches the final iterate against a
// 16-entry root table and returns one result. The block takes one start point at a
// time: s_tready is high only while idle, and the next start point is taken once the
// result has been transferred. All products go through one 64 x 64 multiplier built
// from a single 32 x 32 multiplier, and both quotients of a step go through one
// restoring divider. The default limit is 85 Newton steps per start point.
module complex_newton_root_finder_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // tdata, from bit 0: start_real[63:0], start_imag[63:0]
    input  logic [cnrf_pkg::IN_DATA_W-1:0]   s_tdata,
    // tuser: clear_table
    input  logic                             s_tuser,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tdata, from bit 0: root_real[63:0], root_imag[63:0], slot[3:0], is_new,
    // converged, zero_slope, table_full
    output logic [cnrf_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_wr_en,
    input  logic [cnrf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [63:0]                      cfg_wdata
);
    import cnrf_pkg::*;

    // Configuration
    logic [DEG_W-1:0]   degree_reg;
    word_t              coef_reg [COEFS];
    logic [LIMIT_W-1:0] limit_reg;

    // Sequencer and datapath registers
    state_t state_reg, state_next, hret_reg, hret_next, m2ret_reg, m2ret_next;
    word_t  slope_reg [COEFS], slope_next [COEFS];
    word_t  p_reg [4], p_next [4];
    logic [DEG_W-1:0] sk_reg, sk_next, sj_reg, sj_next, hk_reg, hk_next;
    word_t  sacc_reg, sacc_next;
    word_t  xr_reg, xr_next, xi_reg, xi_next;
    word_t  fre_reg, fre_next, fim_reg, fim_next, gre_reg, gre_next, gim_reg, gim_next;
    word_t  vre_reg, vre_next, vim_reg, vim_next, hxr_reg, hxr_next, hxi_reg, hxi_next;
    word_t  m2a_reg, m2a_next, m2b_reg, m2b_next, q1_reg, q1_next;
    logic   hsel_reg, hsel_next;
    logic [1:0] mi_reg, mi_next;
    logic   mbusy_reg, mbusy_next, dbusy_reg, dbusy_next;
    logic [127:0] m2acc_reg, m2acc_next, fres_reg, fres_next, den_reg, den_next;
    logic [127:0] nacc_reg, nacc_next;
    logic [LIMIT_W-1:0] steps_reg, steps_next;
    logic [CNT_W-1:0]   count_reg, count_next, tk_reg, tk_next;
    logic   conv_reg, conv_next, zs_reg, zs_next, isnew_reg, isnew_next;
    logic   full_reg, full_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;

    // Root table
    word_t  store_re [ROOT_SLOTS];
    word_t  store_im [ROOT_SLOTS];
    word_t  rd_re_reg, rd_im_reg;
    logic   mem_we, mem_re;
    logic [SLOT_W-1:0] mem_waddr, mem_raddr;

    // Shared units
    logic         mul_start, mul_done, div_start, div_done;
    logic [127:0] mul_p;
    word_t        div_q;
    word_t        mul_a, mul_b;
    logic         mul_neg;
    word_t        fm;
    logic [127:0] sp;

    logic [DEG_W-1:0] n_eff, hidx;
    word_t        hcoef;
    logic         iter_go;

    assign n_eff   = (degree_reg > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree_reg;
    assign hidx    = hk_reg - DEG_W'(1);
    assign hcoef   = hsel_reg ? slope_reg[hidx] : coef_reg[hidx];
    assign iter_go = (steps_reg < limit_reg) && (TOL2 < fres_reg);

    // Route operands to the shared multiplier
    always_comb begin
        mul_a = m2a_reg;
        mul_b = m2a_reg;
        case (state_reg)
            S_HMUL: begin
                case (mi_reg)
                    2'd0:    begin mul_a = vre_reg; mul_b = hxr_reg; end
                    2'd1:    begin mul_a = vim_reg; mul_b = hxi_reg; end
                    2'd2:    begin mul_a = vre_reg; mul_b = hxi_reg; end
                    default: begin mul_a = vim_reg; mul_b = hxr_reg; end
                endcase
            end
            S_NUM: begin
                case (mi_reg)
                    2'd0:    begin mul_a = fre_reg; mul_b = gre_reg; end
                    2'd1:    begin mul_a = fim_reg; mul_b = gim_reg; end
                    2'd2:    begin mul_a = fim_reg; mul_b = gre_reg; end
                    default: begin mul_a = fre_reg; mul_b = gim_reg; end
                endcase
            end
            S_M2: begin
                if (mi_reg == 2'd1) begin
                    mul_a = m2b_reg;
                    mul_b = m2b_reg;
                end
            end
            default: ;
        endcase
        mul_neg = mul_a[63] ^ mul_b[63];
        fm      = fmul_post(mul_p, mul_neg);
        sp      = mul_neg ? (128'd0 - mul_p) : mul_p;
    end

    cnrf_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a[63] ? (64'd0 - mul_a) : mul_a),
        .b       (mul_b[63] ? (64'd0 - mul_b) : mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    cnrf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (nacc_reg),
        .den     (den_reg),
        .done    (div_done),
        .q       (div_q)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (s_tvalid) state_next = S_SLOPE;
            S_SLOPE:   if (sk_reg >= n_eff) state_next = S_HSTEP;
            S_HSTEP:   state_next = (hk_reg == '0) ? hret_reg : S_HMUL;
            S_HMUL:    if (mul_done && mi_reg == 2'd3) state_next = S_HADD;
            S_HADD:    state_next = S_HSTEP;
            S_FDONE:   state_next = S_M2;
            S_M2:      if (mul_done && mi_reg == 2'd1) state_next = m2ret_reg;
            S_FRDONE:  state_next = S_CHECK;
            S_CHECK: begin
                if (iter_go && n_eff != '0) state_next = S_HSTEP;
                else                        state_next = S_TSTART;
            end
            S_GDONE:   state_next = S_M2;
            S_DENDONE: state_next = (m2acc_reg == '0) ? S_TSTART : S_NUM;
            S_NUM: begin
                if (mul_done && (mi_reg == 2'd1 || mi_reg == 2'd3)) state_next = S_DIV;
            end
            S_DIV:     if (div_done) state_next = (mi_reg == 2'd2) ? S_NUM : S_XUPD;
            S_XUPD:    state_next = S_HSTEP;
            S_TSTART:  state_next = S_TSCAN;
            S_TSCAN:   state_next = (tk_reg < count_reg) ? S_TRD : S_APPEND;
            S_TRD:     state_next = S_M2;
            S_DDONE:   state_next = (MATCH2 < m2acc_reg) ? S_TSCAN : S_HSTEP;
            S_RDONE:   state_next = S_M2;
            S_RRDONE:  state_next = S_OUT;
            S_APPEND:  state_next = S_OUT;
            S_OUT:     if (m_tready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Datapath and unit controls
    always_comb begin
        word_t s_new;
        hret_next  = hret_reg;
        m2ret_next = m2ret_reg;
        slope_next = slope_reg;
        p_next     = p_reg;
        sk_next    = sk_reg;
        sj_next    = sj_reg;
        hk_next    = hk_reg;
        sacc_next  = sacc_reg;
        xr_next    = xr_reg;
        xi_next    = xi_reg;
        fre_next   = fre_reg;
        fim_next   = fim_reg;
        gre_next   = gre_reg;
        gim_next   = gim_reg;
        vre_next   = vre_reg;
        vim_next   = vim_reg;
        hxr_next   = hxr_reg;
        hxi_next   = hxi_reg;
        m2a_next   = m2a_reg;
        m2b_next   = m2b_reg;
        q1_next    = q1_reg;
        hsel_next  = hsel_reg;
        mi_next    = mi_reg;
        mbusy_next = mbusy_reg;
        dbusy_next = dbusy_reg;
        m2acc_next = m2acc_reg;
        fres_next  = fres_reg;
        den_next   = den_reg;
        nacc_next  = nacc_reg;
        steps_next = steps_reg;
        count_next = count_reg;
        tk_next    = tk_reg;
        conv_next  = conv_reg;
        zs_next    = zs_reg;
        isnew_next = isnew_reg;
        full_next  = full_reg;
        slot_next  = slot_reg;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = tk_reg[SLOT_W-1:0];
        mem_raddr  = tk_reg[SLOT_W-1:0];
        s_new      = sadd64(sacc_reg, coef_reg[sk_reg + DEG_W'(1)]);
        s_tready   = (state_reg == S_IDLE);
        m_tvalid   = (state_reg == S_OUT);

        // Issue a product on the shared multiplier and wait for it
        if (state_reg == S_HMUL || state_reg == S_M2 || state_reg == S_NUM) begin
            if (!mbusy_reg) begin
                mul_start  = 1'b1;
                mbusy_next = 1'b1;
            end
            if (mul_done) mbusy_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    xr_next    = s_tdata[63:0];
                    xi_next    = s_tdata[127:64];
                    if (s_tuser) count_next = '0;
                    steps_next = '0;
                    zs_next    = 1'b0;
                    sk_next    = '0;
                    sj_next    = '0;
                    sacc_next  = '0;
                end
            end
            // Derivative coefficients by repeated saturating addition
            S_SLOPE: begin
                if (sk_reg < n_eff) begin
                    if (sj_reg == sk_reg) begin
                        slope_next[sk_reg] = s_new;
                        sk_next   = sk_reg + DEG_W'(1);
                        sj_next   = '0;
                        sacc_next = '0;
                    end else begin
                        sj_next   = sj_reg + DEG_W'(1);
                        sacc_next = s_new;
                    end
                end else begin
                    hsel_next = 1'b0;
                    hk_next   = n_eff + DEG_W'(1);
                    vre_next  = '0;
                    vim_next  = '0;
                    hxr_next  = xr_reg;
                    hxi_next  = xi_reg;
                    hret_next = S_FDONE;
                end
            end
            S_HSTEP: mi_next = '0;
            S_HMUL: begin
                if (mul_done) begin
                    p_next[mi_reg] = fm;
                    mi_next        = mi_reg + 2'd1;
                end
            end
            // One Horner step: v <- v*x + c
            S_HADD: begin
                vre_next = sadd64(ssub64(p_reg[0], p_reg[1]), hcoef);
                vim_next = sadd64(p_reg[2], p_reg[3]);
                hk_next  = hk_reg - DEG_W'(1);
            end
            S_FDONE: begin
                fre_next   = vre_reg;
                fim_next   = vim_reg;
                m2a_next   = vre_reg;
                m2b_next   = vim_reg;
                m2ret_next = S_FRDONE;
                mi_next    = '0;
            end
            // Squared magnitude, exact at full width
            S_M2: begin
                if (mul_done) begin
                    m2acc_next = (mi_reg == 2'd0) ? mul_p : (m2acc_reg + mul_p);
                    mi_next    = mi_reg + 2'd1;
                end
            end
            S_FRDONE: fres_next = m2acc_reg;
            S_CHECK: begin
                if (iter_go) begin
                    if (n_eff == '0) begin
                        zs_next = 1'b1;
                    end else begin
                        hsel_next = 1'b1;
                        hk_next   = n_eff;
                        vre_next  = '0;
                        vim_next  = '0;
                        hxr_next  = xr_reg;
                        hxi_next  = xi_reg;
                        hret_next = S_GDONE;
                    end
                end
            end
            S_GDONE: begin
                gre_next   = vre_reg;
                gim_next   = vim_reg;
                m2a_next   = vre_reg;
                m2b_next   = vim_reg;
                m2ret_next = S_DENDONE;
                mi_next    = '0;
            end
            S_DENDONE: begin
                den_next = m2acc_reg;
                if (m2acc_reg == '0) zs_next = 1'b1;
                mi_next = '0;
            end
            // Numerators p*conj(p'): real part first, then imaginary part
            S_NUM: begin
                if (mul_done) begin
                    case (mi_reg)
                        2'd0: begin
                            nacc_next = sp;
                            mi_next   = 2'd1;
                        end
                        2'd1: begin
                            nacc_next = nacc_reg + sp;
                            mi_next   = 2'd2;
                        end
                        2'd2: begin
                            nacc_next = sp;
                            mi_next   = 2'd3;
                        end
                        default: nacc_next = nacc_reg - sp;
                    endcase
                end
            end
            S_DIV: begin
                if (!dbusy_reg) begin
                    div_start  = 1'b1;
                    dbusy_next = 1'b1;
                end
                if (div_done) begin
                    dbusy_next = 1'b0;
                    if (mi_reg == 2'd2) q1_next = div_q;
                end
            end
            S_XUPD: begin
                xr_next    = ssub64(xr_reg, q1_reg);
                xi_next    = ssub64(xi_reg, div_q);
                steps_next = steps_reg + LIMIT_W'(1);
                hsel_next  = 1'b0;
                hk_next    = n_eff + DEG_W'(1);
                vre_next   = '0;
                vim_next   = '0;
                hxr_next   = ssub64(xr_reg, q1_reg);
                hxi_next   = ssub64(xi_reg, div_q);
                hret_next  = S_FDONE;
            end
            S_TSTART: begin
                conv_next = !(TOL2 < fres_reg);
                tk_next   = '0;
            end
            S_TSCAN: begin
                if (tk_reg < count_reg) mem_re = 1'b1;
            end
            S_TRD: begin
                m2a_next   = ssub64(rd_re_reg, xr_reg);
                m2b_next   = ssub64(rd_im_reg, xi_reg);
                m2ret_next = S_DDONE;
                mi_next    = '0;
            end
            // On a match, evaluate the residual of the stored root
            S_DDONE: begin
                if (!(MATCH2 < m2acc_reg)) begin
                    hsel_next = 1'b0;
                    hk_next   = n_eff + DEG_W'(1);
                    vre_next  = '0;
                    vim_next  = '0;
                    hxr_next  = rd_re_reg;
                    hxi_next  = rd_im_reg;
                    hret_next = S_RDONE;
                end else begin
                    tk_next = tk_reg + CNT_W'(1);
                end
            end
            S_RDONE: begin
                m2a_next   = vre_reg;
                m2b_next   = vim_reg;
                m2ret_next = S_RRDONE;
                mi_next    = '0;
            end
            // Keep whichever point has the smaller residual
            S_RRDONE: begin
                if (fres_reg < m2acc_reg) mem_we = 1'b1;
                slot_next  = tk_reg[SLOT_W-1:0];
                isnew_next = 1'b0;
                full_next  = 1'b0;
            end
            S_APPEND: begin
                mem_waddr = count_reg[SLOT_W-1:0];
                if (count_reg < CNT_W'(ROOT_SLOTS)) begin
                    mem_we     = 1'b1;
                    slot_next  = count_reg[SLOT_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                    isnew_next = 1'b1;
                    full_next  = 1'b0;
                end else begin
                    slot_next  = '0;
                    isnew_next = 1'b0;
                    full_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Root table: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_re[mem_waddr] <= xr_reg;
            store_im[mem_waddr] <= xi_reg;
        end
        if (mem_re) begin
            rd_re_reg <= store_re[mem_raddr];
            rd_im_reg <= store_im[mem_raddr];
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg <= DEGREE_RESET;
            limit_reg  <= LIMIT_RESET;
            for (int i = 0; i < COEFS; i++) coef_reg[i] <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_DEGREE) degree_reg <= cfg_wdata[DEG_W-1:0];
            if (cfg_index == REG_LIMIT)  limit_reg  <= cfg_wdata[LIMIT_W-1:0];
            if (cfg_index >= REG_COEF_0 && cfg_index <= REG_COEF_5) begin
                coef_reg[cfg_index - REG_COEF_0] <= cfg_wdata;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mbusy_reg <= 1'b0;
            dbusy_reg <= 1'b0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            mbusy_reg <= mbusy_next;
            dbusy_reg <= dbusy_next;
            count_reg <= count_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        hret_reg  <= hret_next;
        m2ret_reg <= m2ret_next;
        slope_reg <= slope_next;
        p_reg     <= p_next;
        sk_reg    <= sk_next;
        sj_reg    <= sj_next;
        hk_reg    <= hk_next;
        sacc_reg  <= sacc_next;
        xr_reg    <= xr_next;
        xi_reg    <= xi_next;
        fre_reg   <= fre_next;
        fim_reg   <= fim_next;
        gre_reg   <= gre_next;
        gim_reg   <= gim_next;
        vre_reg   <= vre_next;
        vim_reg   <= vim_next;
        hxr_reg   <= hxr_next;
        hxi_reg   <= hxi_next;
        m2a_reg   <= m2a_next;
        m2b_reg   <= m2b_next;
        q1_reg    <= q1_next;
        hsel_reg  <= hsel_next;
        mi_reg    <= mi_next;
        m2acc_reg <= m2acc_next;
        fres_reg  <= fres_next;
        den_reg   <= den_next;
        nacc_reg  <= nacc_next;
        steps_reg <= steps_next;
        tk_reg    <= tk_next;
        conv_reg  <= conv_next;
        zs_reg    <= zs_next;
        isnew_reg <= isnew_next;
        full_reg  <= full_next;
        slot_reg  <= slot_next;
    end

    assign m_tdata = {full_reg, zs_reg, conv_reg, isnew_reg, slot_reg, xi_reg, xr_reg};

endmodule

[rtl/cnrf_mul.sv]
// 64 x 64 unsigned multiplier built from one 32 x 32 multiplier over four partial products.
// Depends on cnrf_pkg.
module cnrf_mul (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         done,
    output logic [127:0] p
);
    import cnrf_pkg::*;

    logic [63:0]  a_reg, b_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg, pvalid_reg, done_reg;
    logic [63:0]  prod_reg;
    logic [1:0]   psh_reg;
    logic [127:0] acc_reg;
    logic [31:0]  op_a, op_b;
    logic [1:0]   sh;
    logic [127:0] addend;

    // Select the halves for the partial product of this cycle
    always_comb begin
        op_a = a_reg[31:0];
        op_b = b_reg[31:0];
        sh   = 2'd0;
        case (cnt_reg)
            3'd1: begin
                op_b = b_reg[63:32];
                sh   = 2'd1;
            end
            3'd2: begin
                op_a = a_reg[63:32];
                sh   = 2'd1;
            end
            3'd3: begin
                op_a = a_reg[63:32];
                op_b = b_reg[63:32];
                sh   = 2'd2;
            end
            default: ;
        endcase
    end

    // Align the registered partial product
    always_comb begin
        case (psh_reg)
            2'd1:    addend = 128'(prod_reg) << 32;
            2'd2:    addend = 128'(prod_reg) << 64;
            default: addend = 128'(prod_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            pvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= 3'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg      <= a;
                b_reg      <= b;
                cnt_reg    <= 3'd0;
                busy_reg   <= 1'b1;
                pvalid_reg <= 1'b0;
                acc_reg    <= '0;
            end else if (busy_reg) begin
                if (cnt_reg != 3'd4) begin
                    prod_reg <= op_a * op_b;
                    psh_reg  <= sh;
                end
                pvalid_reg <= 1'b1;
                if (pvalid_reg) acc_reg <= acc_reg + addend;
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

[rtl/cnrf_div.sv]
// Restoring divider for the Newton quotient (num * 2^FRAC_BITS) / den, one bit per cycle.
// Depends on cnrf_pkg; the result is truncated toward zero and saturated.
module cnrf_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [127:0]         num,
    input  logic [127:0]         den,
    output logic                 done,
    output cnrf_pkg::word_t      q
);
    import cnrf_pkg::*;

    logic [127:0]      nsh_reg, den_reg, rem_reg;
    logic [63:0]       quo_reg;
    logic              over_reg, neg_reg, busy_reg, done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    word_t             out_reg;
    logic [127:0]      rem_sh;
    logic              ge;
    logic [63:0]       quo_new;
    logic              over_new;

    // One quotient bit: shift in the next dividend bit, compare, subtract
    always_comb begin
        rem_sh   = {rem_reg[126:0], nsh_reg[127]};
        ge       = rem_sh >= den_reg;
        over_new = over_reg | quo_reg[63];
        quo_new  = {quo_reg[62:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                neg_reg  <= num[127];
                nsh_reg  <= num[127] ? (128'd0 - num) : num;
                den_reg  <= den;
                rem_reg  <= '0;
                quo_reg  <= '0;
                over_reg <= 1'b0;
                cnt_reg  <= DIV_CW'(DIV_STEPS - 1);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                nsh_reg  <= {nsh_reg[126:0], 1'b0};
                rem_reg  <= ge ? (rem_sh - den_reg) : rem_sh;
                quo_reg  <= quo_new;
                over_reg <= over_new;
                cnt_reg  <= cnt_reg - DIV_CW'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    out_reg  <= sat_mag(quo_new, neg_reg, over_new);
                end
            end
        end
    end

    assign done = done_reg;
    assign q    = out_reg;

endmodule
